// File: design/hcff_pkg.sv
package hcff_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned GAIN_W = 32;
    localparam int unsigned LIM_W  = 31;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE   = 2'd2;

    localparam logic [GAIN_W-1:0] MULTIPLIER_RST  = 32'd2621440;
    localparam logic [LIM_W-1:0]  CORE_RADIUS_RST = 31'd983040;
    localparam logic [LIM_W-1:0]  MAX_FORCE_RST   = 31'd216268;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] first_z;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic signed [POS_W-1:0] second_z;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] force_x;
        logic signed [POS_W-1:0] force_y;
        logic signed [POS_W-1:0] force_z;
        logic                    spring_region;
    } t_out_item;

endpackage

// File: design/haptic_charge_force_field.sv
// throughput: one item per cycle; three front stages, an overflow check stage and a
// 31-stage restoring divider (one quotient bit per stage, three axes side by side)
// set the depth; a skid register behind the output lets a held result wait
// without reaching back to the input, the pipeline freezes only once it is full
// reset (synchronous, active low) clears all valid bits and loads the
// register defaults: gain 40.0, core radius 15.0, max force 216268 raw
module haptic_charge_force_field
    import hcff_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // widths: magnitude of a difference fits 32 bits, squares 64, sum of three 66
    localparam int unsigned MAG_W  = 32;
    localparam int unsigned SQ_W   = 64;
    localparam int unsigned DEN_W  = 66;
    localparam int unsigned NUM_W  = 64 + FRAC_BITS;
    localparam int unsigned QW     = 31;
    // remainder must hold the numerator and the divisor at its top shift
    localparam int unsigned RW     = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    typedef struct packed {
        logic [2:0][RW-1:0] rem;
        logic [2:0][QW-1:0] q;
        logic [2:0]         neg;
        logic [2:0]         over;
        logic [DEN_W-1:0]   den;
        logic               zero;
        logic               spring;
    } t_div;

    // configuration registers
    logic [GAIN_W-1:0] r_multiplier;
    logic [LIM_W-1:0]  r_core_radius;
    logic [LIM_W-1:0]  r_max_force;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multiplier  <= MULTIPLIER_RST;
            r_core_radius <= CORE_RADIUS_RST;
            r_max_force   <= MAX_FORCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MULTIPLIER:  r_multiplier  <= i_cfg_data;
                CFG_CORE_RADIUS: r_core_radius <= i_cfg_data[LIM_W-1:0];
                CFG_MAX_FORCE:   r_max_force   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves together while the skid register is empty
    logic r_skid_valid;
    logic w_en;
    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // stage 1: per-axis difference, sign and magnitude
    logic                  r_v1;
    logic [2:0]            r_neg1;
    logic [2:0][MAG_W-1:0] r_mag1;
    logic [2:0]            n_neg1;
    logic [2:0][MAG_W-1:0] n_mag1;
    logic signed [2:0][POS_W:0] w_d;

    always_comb begin
        w_d[0] = {i_in_item.second_x[POS_W-1], i_in_item.second_x}
               - {i_in_item.first_x[POS_W-1], i_in_item.first_x};
        w_d[1] = {i_in_item.second_y[POS_W-1], i_in_item.second_y}
               - {i_in_item.first_y[POS_W-1], i_in_item.first_y};
        w_d[2] = {i_in_item.second_z[POS_W-1], i_in_item.second_z}
               - {i_in_item.first_z[POS_W-1], i_in_item.first_z};
        for (int a = 0; a < 3; a++) begin
            n_neg1[a] = w_d[a][POS_W];
            n_mag1[a] = w_d[a][POS_W] ? MAG_W'(-w_d[a]) : MAG_W'(w_d[a]);
        end
    end

    // stage 2: squares, gain products and radius squared
    logic                  r_v2;
    logic [2:0]            r_neg2;
    logic [2:0][SQ_W-1:0]  r_sq2;
    logic [2:0][SQ_W-1:0]  r_prod2;
    logic [2*LIM_W-1:0]    r_rsq2;

    // stage 3: divisor selection and numerators
    logic                  r_v3;
    logic [2:0]            r_neg3;
    logic [2:0][RW-1:0]    r_num3;
    logic [DEN_W-1:0]      r_den3;
    logic                  r_zero3;
    logic                  r_spring3;
    logic [DEN_W-1:0]      w_d2;
    logic [DEN_W-1:0]      w_core4;
    logic                  w_spring;

    always_comb begin
        w_d2     = DEN_W'(r_sq2[0]) + DEN_W'(r_sq2[1]) + DEN_W'(r_sq2[2]);
        w_core4  = DEN_W'({r_rsq2, 2'b00});
        // squares compared, no root needed
        w_spring = w_d2 < w_core4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg1 <= n_neg1;
            r_mag1 <= n_mag1;
            r_neg2 <= r_neg1;
            for (int a = 0; a < 3; a++) begin
                r_sq2[a]   <= r_mag1[a] * r_mag1[a];
                r_prod2[a] <= r_multiplier * r_mag1[a];
                r_num3[a]  <= RW'({r_prod2[a], {FRAC_BITS{1'b0}}});
            end
            r_rsq2    <= r_core_radius * r_core_radius;
            r_neg3    <= r_neg2;
            r_den3    <= w_spring ? w_core4 : w_d2;
            r_zero3   <= (w_spring ? w_core4 : w_d2) == '0;
            r_spring3 <= w_spring;
        end
    end

    // divider: first stage checks for quotient overflow, then one bit per stage
    logic [QW:0] r_dv;
    t_div        r_div [0:QW];
    t_div        n_div [0:QW];

    always_comb begin
        n_div[0]        = '0;
        n_div[0].den    = r_den3;
        n_div[0].zero   = r_zero3;
        n_div[0].spring = r_spring3;
        n_div[0].neg    = r_neg3;
        for (int a = 0; a < 3; a++) begin
            n_div[0].rem[a]  = r_num3[a];
            n_div[0].over[a] = r_num3[a] >= (RW'(r_den3) << QW);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [RW-1:0] w_sub;
        always_comb begin
            w_sub      = RW'(r_div[k].den) << (QW - 1 - k);
            n_div[k+1] = r_div[k];
            for (int a = 0; a < 3; a++) begin
                if (r_div[k].rem[a] >= w_sub) begin
                    n_div[k+1].rem[a]          = r_div[k].rem[a] - w_sub;
                    n_div[k+1].q[a][QW-1-k]    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[QW-1:0], r_v3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s <= QW; s++) begin
                r_div[s] <= n_div[s];
            end
        end
    end

    // final stage: saturation and sign
    logic [2:0][POS_W-1:0] w_force;
    logic [LIM_W-1:0]      w_mag;
    t_out_item             w_new;
    t_out_item             r_out;
    logic                  r_out_valid;
    t_out_item             r_skid;
    logic                  w_out_free;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_div[QW].zero) begin
                w_mag = '0;
            end else if (r_div[QW].over[a] || r_div[QW].q[a] > r_max_force) begin
                w_mag = r_max_force;
            end else begin
                w_mag = r_div[QW].q[a];
            end
            w_force[a] = r_div[QW].neg[a] ? -{1'b0, w_mag} : {1'b0, w_mag};
        end
        w_new.force_x       = w_force[0];
        w_new.force_y       = w_force[1];
        w_new.force_z       = w_force[2];
        w_new.spring_region = r_div[QW].spring;
    end

    // output register can take an item when empty or when its item leaves
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            // skid item goes first, the pipeline is frozen while it waits
            r_out_valid  <= r_skid_valid || (w_en && r_dv[QW]);
            r_skid_valid <= 1'b0;
        end else if (w_en && r_dv[QW]) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_new;
        end
        if (w_en && !w_out_free) begin
            r_skid <= w_new;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // spring law never selects a zero divisor
    a_spring_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_spring3) |-> (r_den3 != '0))
        else $error("spring law with zero divisor");

    // x force results stay inside the saturation band
    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.force_x <= $signed({1'b0, r_max_force}))
                      && (o_out_item.force_x >= -$signed({1'b0, r_max_force}))))
        else $error("force_x outside saturation band");

    // a zero divisor gives zero force on every axis
    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[QW] && r_div[QW].zero) |-> (w_force == '0))
        else $error("nonzero force from zero divisor");

    // skid register only fills behind a held output item
    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid item without output item");

endmodule
